[hw/rtl/pccf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pccf_pkg
// Shared types, register indexes, reason codes and the CRC-32C byte step.
// ----------------------------------------------------------------------------
package pccf_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned ReasonWidth   = 3;

   localparam logic [31:0] CrcPolyReflected = 32'h82F6_3B78;
   localparam logic [31:0] CrcInit          = 32'hFFFF_FFFF;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegTypeFilterEnable = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegWantedVendor     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegWantedMsgType    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegWantedSource     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegWantedOperator   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegWantedGroup      = 3'd5;

   // reject reason codes
   localparam logic [ReasonWidth-1:0] ReasonPass     = 3'd0;
   localparam logic [ReasonWidth-1:0] ReasonCrc      = 3'd1;
   localparam logic [ReasonWidth-1:0] ReasonVendType = 3'd2;
   localparam logic [ReasonWidth-1:0] ReasonSource   = 3'd3;
   localparam logic [ReasonWidth-1:0] ReasonOperator = 3'd4;
   localparam logic [ReasonWidth-1:0] ReasonGroup    = 3'd5;

   typedef struct packed {
      logic        type_filter_enable;
      logic [31:0] wanted_vendor;
      logic [31:0] wanted_msg_type;
      logic [31:0] wanted_source;
      logic [31:0] wanted_operator;
      logic [31:0] wanted_group;
   } cfg_type;

   typedef struct packed {
      logic        crc_present;
      logic [31:0] stored_crc;
      logic [31:0] vendor_id;
      logic [31:0] msg_type;
      logic [31:0] source_id;
      logic [31:0] operator_id;
      logic [31:0] group_id;
   } ids_type;

   // one reflected CRC-32C byte step, eight bit shifts
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = {1'b0, c[31:1]} ^ CrcPolyReflected;
         end else begin
            c = {1'b0, c[31:1]};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/pccf_crc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pccf_crc
// Running CRC-32C register with at most one byte update per advanced item.
// ----------------------------------------------------------------------------
module pccf_crc (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        has_byte,
   input  wire logic        last,
   input  wire logic [7:0]  data_byte,
   output logic      [31:0] final_crc
);
   import pccf_pkg::*;

   logic [31:0] running_crc_ff;
   logic [31:0] running_crc_in;
   logic [31:0] crc_next;

   always_comb begin
      crc_next       = has_byte ? crc32c_byte(running_crc_ff, data_byte) : running_crc_ff;
      final_crc      = ~crc_next;
      // reload after each payload
      running_crc_in = last ? CrcInit : crc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= CrcInit;
      end else if (step) begin
         running_crc_ff <= running_crc_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/pccf_verdict.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pccf_verdict
// Ordered CRC and id checks; the first failing check names the reason.
// ----------------------------------------------------------------------------
module pccf_verdict (
   input  wire pccf_pkg::cfg_type      cfg,
   input  wire pccf_pkg::ids_type      ids,
   input  wire logic [31:0]            final_crc,
   output logic [pccf_pkg::ReasonWidth-1:0] reason
);
   import pccf_pkg::*;

   logic [31:0] wire_swapped;

   always_comb begin
      wire_swapped = {ids.stored_crc[7:0], ids.stored_crc[15:8],
                      ids.stored_crc[23:16], ids.stored_crc[31:24]};
      if (ids.crc_present && (wire_swapped != final_crc)) begin
         reason = ReasonCrc;
      end else if (cfg.type_filter_enable &&
                   ((cfg.wanted_vendor != ids.vendor_id) ||
                    (cfg.wanted_msg_type != ids.msg_type))) begin
         reason = ReasonVendType;
      end else if ((cfg.wanted_source != 32'd0) && (cfg.wanted_source != ids.source_id)) begin
         reason = ReasonSource;
      end else if ((cfg.wanted_operator != 32'd0) &&
                   (cfg.wanted_operator != ids.operator_id)) begin
         reason = ReasonOperator;
      end else if ((cfg.wanted_group != 32'd0) && (cfg.wanted_group != ids.group_id)) begin
         reason = ReasonGroup;
      end else begin
         reason = ReasonPass;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/payload_crc_check_and_field_filter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// payload_crc_check_and_field_filter_top
// CRC-32C check over a byte stream with vendor/type/source/operator/group
// filtering of each payload.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one payload byte per item; tlast marks the final item of a
//          payload, tuser[0] says the byte is real (clear it with tlast set
//          for an empty payload), tuser[1] says a wire CRC is present.
//   rsp_*  gives one verdict item per payload: accept, reason, computed CRC.
//   csr_*  writes a filter register by index; always ready. Write only
//          while no payload is in flight.
// Path: an item is held in an input register, then its verdict lands in the
//   result register, which drives rsp_tvalid; a held verdict can keep a
//   last item waiting in the input register.
// Throughput: one item per cycle, set by the single byte-wide CRC step
//   between the input and result registers, while no held verdict stalls a last item.
// Reset: clears valids, all filter registers and loads the running CRC with
//   all ones.
// Stall: while rsp_tready is low the verdict holds; one more last item can
//   wait in the input register, and until one does, bytes that produce no
//   verdict keep flowing through it.
// ----------------------------------------------------------------------------
module payload_crc_check_and_field_filter_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // input stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [7:0] data_byte, [39:8] stored_crc, [71:40] vendor_id, [103:72] msg_type,
   // [135:104] source_id, [167:136] operator_id, [199:168] group_id
   input  wire logic [199:0] req_tdata,
   // [0] has_byte, [1] crc_present
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tlast,
   // result stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] accept, [3:1] reject_reason, [35:4] computed_crc, [39:36] zero
   output logic [39:0]       rsp_tdata,
   // configuration write
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [pccf_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [31:0]  csr_data
);
   import pccf_pkg::*;

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // input register stage
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_has_byte_ff;
   logic        s1_last_ff;
   ids_type     s1_ids_ff;

   // result register stage
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [ReasonWidth-1:0] rsp_reason_ff;
   logic [31:0]            rsp_crc_ff;

   logic                   rsp_free;
   logic                   s1_step;
   logic                   req_fire;
   logic [31:0]            final_crc;
   logic [ReasonWidth-1:0] reason;

   assign csr_ready = 1'b1;

   // decode configuration writes; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            RegTypeFilterEnable: cfg_in.type_filter_enable = csr_data[0];
            RegWantedVendor:     cfg_in.wanted_vendor      = csr_data;
            RegWantedMsgType:    cfg_in.wanted_msg_type    = csr_data;
            RegWantedSource:     cfg_in.wanted_source      = csr_data;
            RegWantedOperator:   cfg_in.wanted_operator    = csr_data;
            RegWantedGroup:      cfg_in.wanted_group       = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: the result register frees when empty or being taken;
   // a non-last item never needs it
   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_tready;
      s1_step      = s1_valid_ff && (!s1_last_ff || rsp_free);
      req_tready   = !s1_valid_ff || s1_step;
      req_fire     = req_tvalid && req_tready;
      s1_valid_in  = req_fire ? 1'b1 : (s1_step ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (s1_step && s1_last_ff) ? 1'b1 :
                     (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff            <= req_tdata[7:0];
         s1_has_byte_ff        <= req_tuser[0];
         s1_last_ff            <= req_tlast;
         s1_ids_ff.crc_present <= req_tuser[1];
         s1_ids_ff.stored_crc  <= req_tdata[39:8];
         s1_ids_ff.vendor_id   <= req_tdata[71:40];
         s1_ids_ff.msg_type    <= req_tdata[103:72];
         s1_ids_ff.source_id   <= req_tdata[135:104];
         s1_ids_ff.operator_id <= req_tdata[167:136];
         s1_ids_ff.group_id    <= req_tdata[199:168];
      end
   end

   pccf_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_step),
      .has_byte  (s1_has_byte_ff),
      .last      (s1_last_ff),
      .data_byte (s1_byte_ff),
      .final_crc (final_crc)
   );

   pccf_verdict u_verdict (
      .cfg       (cfg_ff),
      .ids       (s1_ids_ff),
      .final_crc (final_crc),
      .reason    (reason)
   );

   // load the verdict
   always_ff @(posedge clock) begin
      if (s1_step && s1_last_ff) begin
         rsp_reason_ff <= reason;
         rsp_crc_ff    <= final_crc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_crc_ff, rsp_reason_ff, (rsp_reason_ff == ReasonPass)};

endmodule
`default_nettype wire
